// ----- rtl/cnms_pkg.sv -----
`timescale 1ns / 1ps
// Package with the shared constants, codes and types of the nonmaximum suppression block.
package cnms_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int GRAD_BITS_DEF = 16;
    localparam int LINE_LIMIT    = 1024;

    localparam int COL_BITS     = 10;
    localparam int ROW_BITS     = 11;
    localparam int CFG_BITS     = 11;
    localparam int MAG_OUT_BITS = 16;

    localparam int TAN_BITS = 15;
    localparam int TAN_FRAC = 16;
    localparam logic [TAN_BITS-1:0] TAN_PI_8_Q16 = 15'd27146;

    localparam logic [CFG_BITS-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [CFG_BITS-1:0] HEIGHT_RESET = 11'd480;
    localparam logic [CFG_BITS-1:0] DIM_MIN      = 11'd3;
    localparam logic [CFG_BITS-1:0] HEIGHT_MAX   = 11'd1024;

    typedef enum logic [1:0] {
        DIR_HORZ = 2'd0,
        DIR_MAIN = 2'd1,
        DIR_VERT = 2'd2,
        DIR_ANTI = 2'd3
    } t_dir;

    typedef enum logic {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic                emit;
        logic                fend;
        logic                border;
        logic [COL_BITS-1:0] col;
        logic [COL_BITS-1:0] ocol;
        logic [COL_BITS-1:0] orow;
    } t_pix_meta;

    typedef struct packed {
        logic [MAG_OUT_BITS-1:0] edge_mag;
        logic [COL_BITS-1:0]     out_col;
        logic [COL_BITS-1:0]     out_row;
        logic                    frame_end;
    } t_result;

endpackage

// ----- rtl/cnms_in_if.sv -----
`timescale 1ns / 1ps
// Interface of the gradient request channel.
interface cnms_in_if #(
    parameter int GRAD_BITS = cnms_pkg::GRAD_BITS_DEF
) ();
    logic                        valid;
    logic                        ready;
    logic signed [GRAD_BITS-1:0] grad_x;
    logic signed [GRAD_BITS-1:0] grad_y;
    logic                        drain;

    modport source (output valid, grad_x, grad_y, drain, input ready);
    modport sink (input valid, grad_x, grad_y, drain, output ready);
endinterface

// ----- rtl/cnms_out_if.sv -----
`timescale 1ns / 1ps
// Interface of the suppressed magnitude result channel.
interface cnms_out_if ();
    logic                                  valid;
    logic                                  ready;
    logic [cnms_pkg::MAG_OUT_BITS-1:0]     edge_mag;
    logic [cnms_pkg::COL_BITS-1:0]         out_col;
    logic [cnms_pkg::COL_BITS-1:0]         out_row;
    logic                                  frame_end;

    modport source (output valid, edge_mag, out_col, out_row, frame_end, input ready);
    modport sink (input valid, edge_mag, out_col, out_row, frame_end, output ready);
endinterface

// ----- rtl/cnms_cfg_if.sv -----
`timescale 1ns / 1ps
// Interface of the configuration register write channel.
interface cnms_cfg_if ();
    logic                          valid;
    logic                          ready;
    cnms_pkg::t_cfg_reg            reg_index;
    logic [cnms_pkg::CFG_BITS-1:0] wr_data;

    modport source (output valid, reg_index, wr_data, input ready);
    modport sink (input valid, reg_index, wr_data, output ready);
endinterface

// ----- rtl/cnms_grad_dir.sv -----
`timescale 1ns / 1ps
// Three-stage pipeline that forms gradient magnitude and quantized direction.
module cnms_grad_dir #(
    parameter int GRAD_BITS = cnms_pkg::GRAD_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_adv,
    input  logic                            i_load,
    input  logic signed [GRAD_BITS-1:0]     i_gx,
    input  logic signed [GRAD_BITS-1:0]     i_gy,
    input  cnms_pkg::t_pix_meta             i_meta,
    output logic [cnms_pkg::COL_BITS-1:0]   o_rd_col,
    output logic                            o_valid,
    output cnms_pkg::t_pix_meta             o_meta,
    output logic [GRAD_BITS-1:0]            o_mag,
    output cnms_pkg::t_dir                  o_dir
);
    localparam int PW = GRAD_BITS + cnms_pkg::TAN_BITS;
    localparam int CW = GRAD_BITS + cnms_pkg::TAN_FRAC;

    logic                  r_s1_valid;
    logic [GRAD_BITS-1:0]  r_s1_gx;
    logic [GRAD_BITS-1:0]  r_s1_gy;
    cnms_pkg::t_pix_meta   r_s1_meta;

    logic                  r_s2_valid;
    logic [GRAD_BITS-1:0]  r_s2_ax;
    logic [GRAD_BITS-1:0]  r_s2_ay;
    logic                  r_s2_nx;
    logic                  r_s2_ny;
    cnms_pkg::t_pix_meta   r_s2_meta;

    logic                  r_s3_valid;
    logic [GRAD_BITS-1:0]  r_s3_ax;
    logic [GRAD_BITS-1:0]  r_s3_ay;
    logic                  r_s3_nx;
    logic                  r_s3_ny;
    logic [PW-1:0]         r_s3_px;
    logic [PW-1:0]         r_s3_py;
    cnms_pkg::t_pix_meta   r_s3_meta;

    logic [GRAD_BITS-1:0]  n_ax;
    logic [GRAD_BITS-1:0]  n_ay;
    logic [PW-1:0]         n_px;
    logic [PW-1:0]         n_py;
    logic                  horz;
    logic                  vert;

    assign n_ax = r_s1_gx[GRAD_BITS-1] ? (~r_s1_gx + GRAD_BITS'(1)) : r_s1_gx;
    assign n_ay = r_s1_gy[GRAD_BITS-1] ? (~r_s1_gy + GRAD_BITS'(1)) : r_s1_gy;
    assign n_px = PW'(r_s2_ax) * PW'(cnms_pkg::TAN_PI_8_Q16);
    assign n_py = PW'(r_s2_ay) * PW'(cnms_pkg::TAN_PI_8_Q16);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else if (i_adv) begin
            r_s1_valid <= i_load;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s1_gx   <= i_gx;
            r_s1_gy   <= i_gy;
            r_s1_meta <= i_meta;
            r_s2_ax   <= n_ax;
            r_s2_ay   <= n_ay;
            r_s2_nx   <= r_s1_gx[GRAD_BITS-1];
            r_s2_ny   <= r_s1_gy[GRAD_BITS-1];
            r_s2_meta <= r_s1_meta;
            r_s3_ax   <= r_s2_ax;
            r_s3_ay   <= r_s2_ay;
            r_s3_nx   <= r_s2_nx;
            r_s3_ny   <= r_s2_ny;
            r_s3_px   <= n_px;
            r_s3_py   <= n_py;
            r_s3_meta <= r_s2_meta;
        end
    end

    assign horz = {r_s3_ay, {cnms_pkg::TAN_FRAC{1'b0}}} <= CW'(r_s3_px);
    assign vert = {r_s3_ax, {cnms_pkg::TAN_FRAC{1'b0}}} <= CW'(r_s3_py);

    always_comb begin
        if (horz) begin
            o_dir = cnms_pkg::DIR_HORZ;
        end else if (vert) begin
            o_dir = cnms_pkg::DIR_VERT;
        end else if (r_s3_nx == r_s3_ny) begin
            o_dir = cnms_pkg::DIR_MAIN;
        end else begin
            o_dir = cnms_pkg::DIR_ANTI;
        end
    end

    assign o_mag    = (r_s3_ax > r_s3_ay) ? r_s3_ax : r_s3_ay;
    assign o_valid  = r_s3_valid;
    assign o_meta   = r_s3_meta;
    assign o_rd_col = r_s2_meta.col;
endmodule

// ----- rtl/cnms_line_mem.sv -----
`timescale 1ns / 1ps
// Line memory holding the two previous rows of magnitude and the center row direction.
module cnms_line_mem #(
    parameter int DEPTH = cnms_pkg::LINE_LIMIT,
    parameter int DW    = 34
) (
    input  logic                     i_clk,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [DW-1:0]            o_rd_data,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [DW-1:0]            i_wr_data
);
    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// ----- rtl/cnms_nms.sv -----
`timescale 1ns / 1ps
// Three by three magnitude window with the suppression decision along the direction.
module cnms_nms #(
    parameter int GRAD_BITS = cnms_pkg::GRAD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  logic                  i_valid,
    input  cnms_pkg::t_pix_meta   i_meta,
    input  logic [GRAD_BITS-1:0]  i_mag,
    input  logic [GRAD_BITS-1:0]  i_top,
    input  logic [GRAD_BITS-1:0]  i_mid,
    input  cnms_pkg::t_dir        i_dir_rd,
    output logic                  o_res_valid,
    output cnms_pkg::t_result     o_res
);
    localparam int MXW = (GRAD_BITS > cnms_pkg::MAG_OUT_BITS) ? GRAD_BITS
                                                             : cnms_pkg::MAG_OUT_BITS;

    logic [GRAD_BITS-1:0]  r_win [9];
    cnms_pkg::t_dir        r_dir_now;
    cnms_pkg::t_dir        r_dir_prev;
    logic                  r_s4_valid;
    cnms_pkg::t_pix_meta   r_s4_meta;

    logic [GRAD_BITS-1:0]  ctr;
    logic [GRAD_BITS-1:0]  n1;
    logic [GRAD_BITS-1:0]  n2;
    logic                  suppress;
    logic [MXW-1:0]        mag_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
        end else if (i_adv) begin
            r_s4_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s4_meta <= i_meta;
        end
        if (i_adv && i_valid) begin
            for (int k = 0; k < 3; k++) begin
                r_win[3*k]   <= r_win[3*k+1];
                r_win[3*k+1] <= r_win[3*k+2];
            end
            r_win[2]   <= i_top;
            r_win[5]   <= i_mid;
            r_win[8]   <= i_mag;
            r_dir_now  <= i_dir_rd;
            r_dir_prev <= r_dir_now;
        end
    end

    always_comb begin
        case (r_dir_prev)
            cnms_pkg::DIR_MAIN: begin
                n1 = r_win[0];
                n2 = r_win[8];
            end
            cnms_pkg::DIR_VERT: begin
                n1 = r_win[1];
                n2 = r_win[7];
            end
            cnms_pkg::DIR_ANTI: begin
                n1 = r_win[2];
                n2 = r_win[6];
            end
            default: begin
                n1 = r_win[3];
                n2 = r_win[5];
            end
        endcase
    end

    assign ctr      = r_win[4];
    assign suppress = !r_s4_meta.border && ((ctr < n1) || (ctr < n2));
    assign mag_ext  = suppress ? '0 : MXW'(ctr);

    assign o_res_valid     = r_s4_valid && r_s4_meta.emit;
    assign o_res.edge_mag  = mag_ext[cnms_pkg::MAG_OUT_BITS-1:0];
    assign o_res.out_col   = r_s4_meta.ocol;
    assign o_res.out_row   = r_s4_meta.orow;
    assign o_res.frame_end = r_s4_meta.fend;
endmodule

// ----- rtl/canny_nonmax_suppression.sv -----
`timescale 1ns / 1ps
// Top level of the streaming Canny nonmaximum suppression block.
//
//  channel   modport  handshake     payload
//  i_pix     sink     valid/ready   grad_x, grad_y, drain
//  i_cfg     sink     valid/ready   reg_index, wr_data
//  o_edge    source   valid/ready   edge_mag, out_col, out_row, frame_end
//
// While ready, one request is taken and the line memory does one read and one write per cycle.
// A result goes through registers s1, s2, s3, the window register and the output register.
// i_pix.ready falls only while the output register holds a result that o_edge does not take.
// Reset is synchronous and clears counters and valid flags; the line memory needs no clearing.
// A configuration write takes effect at once and restarts the frame at row zero, column zero.
module canny_nonmax_suppression #(
    parameter int MAX_WIDTH = cnms_pkg::MAX_WIDTH_DEF,
    parameter int GRAD_BITS = cnms_pkg::GRAD_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cnms_in_if.sink     i_pix,
    cnms_cfg_if.sink    i_cfg,
    cnms_out_if.source  o_edge
);
    localparam int LINE_DEPTH = (MAX_WIDTH < cnms_pkg::LINE_LIMIT) ? MAX_WIDTH
                                                                   : cnms_pkg::LINE_LIMIT;
    localparam int LINE_AW = $clog2(LINE_DEPTH);
    localparam int LINE_DW = 2 * GRAD_BITS + 2;
    localparam logic [cnms_pkg::CFG_BITS-1:0] WIDTH_MAX = cnms_pkg::CFG_BITS'(LINE_DEPTH);

    function automatic logic [cnms_pkg::CFG_BITS-1:0] clamp_dim(
        input logic [cnms_pkg::CFG_BITS-1:0] v,
        input logic [cnms_pkg::CFG_BITS-1:0] hi
    );
        logic [cnms_pkg::CFG_BITS-1:0] res;
        res = v;
        if (v < cnms_pkg::DIM_MIN) begin
            res = cnms_pkg::DIM_MIN;
        end else if (v > hi) begin
            res = hi;
        end
        return res;
    endfunction

    logic [cnms_pkg::CFG_BITS-1:0] r_eff_w;
    logic [cnms_pkg::CFG_BITS-1:0] r_eff_h;
    logic [cnms_pkg::COL_BITS-1:0] r_col;
    logic [cnms_pkg::ROW_BITS-1:0] r_row;
    logic                          r_out_valid;
    cnms_pkg::t_result             r_out;

    logic                          adv;
    logic                          cfg_wr;
    logic                          flushing;
    logic                          take;
    logic                          emit;
    logic                          fend;
    logic [cnms_pkg::CFG_BITS-1:0] col_plus;
    logic [cnms_pkg::COL_BITS-1:0] n_col;
    logic [cnms_pkg::ROW_BITS-1:0] n_row;
    logic [cnms_pkg::COL_BITS-1:0] orow;
    logic [cnms_pkg::COL_BITS-1:0] ocol;
    logic                          border;
    cnms_pkg::t_pix_meta           meta;
    logic signed [GRAD_BITS-1:0]   gx;
    logic signed [GRAD_BITS-1:0]   gy;

    logic [cnms_pkg::COL_BITS-1:0] rd_col;
    logic                          s3_valid;
    cnms_pkg::t_pix_meta           s3_meta;
    logic [GRAD_BITS-1:0]          s3_mag;
    cnms_pkg::t_dir                s3_dir;
    logic [LINE_DW-1:0]            rd_data;
    logic [LINE_DW-1:0]            wr_data;
    logic                          res_valid;
    cnms_pkg::t_result             res;

    assign adv         = !r_out_valid || o_edge.ready;
    assign i_pix.ready = adv;
    assign i_cfg.ready = 1'b1;
    assign cfg_wr      = i_cfg.valid;

    assign flushing = r_row >= r_eff_h;
    assign take     = i_pix.valid && adv && (flushing || !i_pix.drain);
    assign emit     = (r_row >= cnms_pkg::ROW_BITS'(2))
                   || ((r_row == cnms_pkg::ROW_BITS'(1)) && (r_col != '0));
    assign fend     = (r_row == (r_eff_h + cnms_pkg::ROW_BITS'(1))) && (r_col == '0);

    assign col_plus = {1'b0, r_col} + cnms_pkg::CFG_BITS'(1);

    always_comb begin
        if (fend) begin
            n_col = '0;
            n_row = '0;
        end else if (col_plus == r_eff_w) begin
            n_col = '0;
            n_row = r_row + cnms_pkg::ROW_BITS'(1);
        end else begin
            n_col = col_plus[cnms_pkg::COL_BITS-1:0];
            n_row = r_row;
        end
    end

    always_comb begin
        if (r_col != '0) begin
            orow = cnms_pkg::COL_BITS'(r_row - cnms_pkg::ROW_BITS'(1));
            ocol = r_col - cnms_pkg::COL_BITS'(1);
        end else begin
            orow = cnms_pkg::COL_BITS'(r_row - cnms_pkg::ROW_BITS'(2));
            ocol = cnms_pkg::COL_BITS'(r_eff_w - cnms_pkg::CFG_BITS'(1));
        end
    end

    assign border = (orow == '0) || ({1'b0, orow} == r_eff_h - cnms_pkg::CFG_BITS'(1))
                 || (ocol == '0) || ({1'b0, ocol} == r_eff_w - cnms_pkg::CFG_BITS'(1));

    assign meta.emit   = emit;
    assign meta.fend   = fend;
    assign meta.border = border;
    assign meta.col    = r_col;
    assign meta.ocol   = ocol;
    assign meta.orow   = orow;

    assign gx = flushing ? '0 : i_pix.grad_x;
    assign gy = flushing ? '0 : i_pix.grad_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eff_w <= cnms_pkg::WIDTH_RESET;
            r_eff_h <= cnms_pkg::HEIGHT_RESET;
        end else if (cfg_wr) begin
            case (i_cfg.reg_index)
                cnms_pkg::CFG_IMAGE_WIDTH: begin
                    r_eff_w <= clamp_dim(i_cfg.wr_data, WIDTH_MAX);
                end
                cnms_pkg::CFG_IMAGE_HEIGHT: begin
                    r_eff_h <= clamp_dim(i_cfg.wr_data, cnms_pkg::HEIGHT_MAX);
                end
                default: begin
                    r_eff_w <= r_eff_w;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (cfg_wr) begin
            r_col <= '0;
            r_row <= '0;
        end else if (take) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    cnms_grad_dir #(
        .GRAD_BITS (GRAD_BITS)
    ) u_grad_dir (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_load   (take),
        .i_gx     (gx),
        .i_gy     (gy),
        .i_meta   (meta),
        .o_rd_col (rd_col),
        .o_valid  (s3_valid),
        .o_meta   (s3_meta),
        .o_mag    (s3_mag),
        .o_dir    (s3_dir)
    );

    assign wr_data = {rd_data[LINE_DW-GRAD_BITS-1:2], s3_mag, s3_dir};

    cnms_line_mem #(
        .DEPTH (LINE_DEPTH),
        .DW    (LINE_DW)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_rd_en   (adv),
        .i_rd_addr (rd_col[LINE_AW-1:0]),
        .o_rd_data (rd_data),
        .i_wr_en   (adv && s3_valid),
        .i_wr_addr (s3_meta.col[LINE_AW-1:0]),
        .i_wr_data (wr_data)
    );

    cnms_nms #(
        .GRAD_BITS (GRAD_BITS)
    ) u_nms (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_valid     (s3_valid),
        .i_meta      (s3_meta),
        .i_mag       (s3_mag),
        .i_top       (rd_data[LINE_DW-1:LINE_DW-GRAD_BITS]),
        .i_mid       (rd_data[LINE_DW-GRAD_BITS-1:2]),
        .i_dir_rd    (cnms_pkg::t_dir'(rd_data[1:0])),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= res;
        end
    end

    assign o_edge.valid     = r_out_valid;
    assign o_edge.edge_mag  = r_out.edge_mag;
    assign o_edge.out_col   = r_out.out_col;
    assign o_edge.out_row   = r_out.out_row;
    assign o_edge.frame_end = r_out.frame_end;

`ifndef SYNTHESIS
    a_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_col} < r_eff_w)
        else $error("Column counter reached the row width.");

    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= r_eff_h + cnms_pkg::ROW_BITS'(1))
        else $error("Row counter ran past the flush rows.");

    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && fend |=> (r_row == '0) && (r_col == '0))
        else $error("Frame end did not restart the counters.");
`endif
endmodule
